### hdl/assert_macros.svh
// Assertion macros used by the engine's sequencer, i2cmwr_seq.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/i2cmwr_pkg.sv
// Shared types and constants of the I2C master write/read engine.
// No dependencies.
package i2cmwr_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_STRETCH = 2'd1;
	localparam logic [1:0] ERR_NACK    = 2'd2;

	localparam logic REG_HALF_PERIOD = 1'b0;
	localparam logic REG_TIMEOUT     = 1'b1;

	localparam logic [9:0]  HALF_PERIOD_RESET = 10'd5;
	localparam logic [15:0] TIMEOUT_RESET     = 16'd12000;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  write_byte;
		logic [7:0]  slave_address;
		logic [4:0]  write_count;
		logic [15:0] read_count;
		logic        scl_in;
		logic        sda_in;
	} item_t;

	typedef struct packed {
		logic        scl_drive_low;
		logic        sda_drive_low;
		logic        read_valid;
		logic [7:0]  read_byte;
		logic        read_last;
		logic        busy_res;
		logic        done_res;
		logic [1:0]  error_kind;
	} res_t;

endpackage

### hdl/i2cmwr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2cmwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/i2cmwr_skid.sv
// Output register with skid stage for the result stream.
// No dependencies.
module i2cmwr_skid #(
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] out_data
);

	logic          out_valid_q;
	logic [DW-1:0] out_data_q;
	logic          skid_valid_q;
	logic [DW-1:0] skid_data_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_valid) begin
				out_data_q <= in_data;
			end
		end else if (in_valid && in_ready) begin
			skid_data_q <= in_data;
		end
	end

endmodule

### hdl/i2cmwr_seq.sv
// Bus sequencer: one tick per transaction, write bytes held in a synchronous RAM.
// Depends on i2cmwr_pkg, i2cmwr_ram and assert_macros.svh.
`include "assert_macros.svh"

module i2cmwr_seq #(
	parameter int WRITE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  i2cmwr_pkg::item_t  item,
	input  logic [9:0]         half_period_ticks,
	input  logic [15:0]        stretch_timeout_ticks,
	output i2cmwr_pkg::res_t   res
);
	import i2cmwr_pkg::*;

	localparam int PW = $clog2(WRITE_DEPTH + 1);
	localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

	localparam logic [4:0] PH_IDLE  = 5'd0;
	localparam logic [4:0] ST_WAIT  = 5'd1;
	localparam logic [4:0] ST_SDA   = 5'd2;
	localparam logic [4:0] ST_SCL   = 5'd3;
	localparam logic [4:0] TX_SETUP = 5'd4;
	localparam logic [4:0] TX_WAIT  = 5'd5;
	localparam logic [4:0] TX_HIGH  = 5'd6;
	localparam logic [4:0] AK_SETUP = 5'd7;
	localparam logic [4:0] AK_WAIT  = 5'd8;
	localparam logic [4:0] AK_HIGH  = 5'd9;
	localparam logic [4:0] AK_LOW   = 5'd10;
	localparam logic [4:0] RS_REL   = 5'd11;
	localparam logic [4:0] RS_WAIT  = 5'd12;
	localparam logic [4:0] RS_HIGH  = 5'd13;
	localparam logic [4:0] RS_SDA   = 5'd14;
	localparam logic [4:0] RS_SCL   = 5'd15;
	localparam logic [4:0] RX_REL   = 5'd16;
	localparam logic [4:0] RX_WAIT  = 5'd17;
	localparam logic [4:0] RX_HIGH  = 5'd18;
	localparam logic [4:0] RX_LOW   = 5'd19;
	localparam logic [4:0] MA_SETUP = 5'd20;
	localparam logic [4:0] MA_HIGH  = 5'd21;
	localparam logic [4:0] MA_LOW   = 5'd22;
	localparam logic [4:0] SP_SCL   = 5'd23;
	localparam logic [4:0] SP_SDA   = 5'd24;
	localparam logic [4:0] SP_WAIT  = 5'd25;
	localparam logic [4:0] SP_HIGH  = 5'd26;
	localparam logic [4:0] SP_REL   = 5'd27;

	logic [4:0]    phase_q, phase_d, nxt;
	logic          go;
	logic [2:0]    bit_q, bit_d;
	logic [7:0]    shift_q, shift_d;
	logic [15:0]   bytes_left_q, bytes_left_d, bl_dec;
	logic [PW-1:0] lp_q, lp_d;
	logic [PW-1:0] sp_q, sp_d;
	logic [PW-1:0] hwc_q, hwc_d;
	logic [9:0]    ptimer_q, ptimer_d, ptimer_inc, hp;
	logic [15:0]   stimer_q, stimer_d, stimer_inc, to;
	logic          is_read_q, is_read_d;
	logic [7:0]    addr_q, addr_d;
	logic [1:0]    err_q, err_d;
	logic          in_rd_q, in_rd_d;
	logic          nack_q, nack_d;
	logic          hold_done, scl_up, scl_timeout;
	logic          buf_we;
	logic [7:0]    buf_rdata;
	logic [PW-1:0] raddr_ptr;
	res_t          res_d;

	assign buf_we    = accept && phase_q == PH_IDLE && item.op == OP_LOAD
		&& lp_q < PW'(WRITE_DEPTH);
	assign raddr_ptr = accept ? sp_d : sp_q;

	i2cmwr_ram #(.WIDTH(8), .DEPTH(WRITE_DEPTH)) u_wbuf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (lp_q[AW-1:0]),
		.wdata (item.write_byte),
		.raddr (raddr_ptr[AW-1:0]),
		.rdata (buf_rdata)
	);

	assign hp          = (half_period_ticks == '0) ? 10'd1 : half_period_ticks;
	assign to          = (stretch_timeout_ticks == '0) ? 16'd1 : stretch_timeout_ticks;
	assign ptimer_inc  = ptimer_q + 10'd1;
	assign stimer_inc  = stimer_q + 16'd1;
	assign hold_done   = ptimer_inc >= hp;
	assign scl_up      = item.scl_in;
	assign scl_timeout = !item.scl_in && stimer_inc >= to;
	assign bl_dec      = (bytes_left_q != '0) ? bytes_left_q - 16'd1 : bytes_left_q;

	always_comb begin
		phase_d      = phase_q;
		bit_d        = bit_q;
		shift_d      = shift_q;
		bytes_left_d = bytes_left_q;
		lp_d         = lp_q;
		sp_d         = sp_q;
		hwc_d        = hwc_q;
		ptimer_d     = ptimer_q;
		stimer_d     = stimer_q;
		is_read_d    = is_read_q;
		addr_d       = addr_q;
		err_d        = err_q;
		in_rd_d      = in_rd_q;
		nack_d       = nack_q;
		go           = 1'b0;
		nxt          = phase_q;
		res_d        = '0;

		case (phase_q)
			PH_IDLE: begin
				if (item.op == OP_LOAD) begin
					if (lp_q < PW'(WRITE_DEPTH)) begin
						lp_d = lp_q + PW'(1);
					end
				end else if (item.op == OP_WRITE || item.op == OP_READ) begin
					addr_d = item.slave_address;
					if (int'(item.write_count) > WRITE_DEPTH) begin
						hwc_d = PW'(WRITE_DEPTH);
					end else begin
						hwc_d = PW'(item.write_count);
					end
					is_read_d    = item.op == OP_READ;
					bytes_left_d = (item.op == OP_READ) ? item.read_count : 16'd0;
					sp_d         = '0;
					lp_d         = '0;
					err_d        = ERR_NONE;
					in_rd_d      = 1'b0;
					nack_d       = 1'b0;
					bit_d        = '0;
					shift_d      = '0;
					go           = 1'b1;
					nxt          = ST_WAIT;
				end
			end
			ST_WAIT, TX_WAIT, RS_WAIT, RX_WAIT, AK_WAIT: begin
				if (scl_up) begin
					go = 1'b1;
					case (phase_q)
						ST_WAIT: nxt = ST_SDA;
						TX_WAIT: nxt = TX_HIGH;
						RS_WAIT: nxt = RS_HIGH;
						RX_WAIT: nxt = RX_HIGH;
						default: begin
							nxt    = AK_HIGH;
							nack_d = item.sda_in;
						end
					endcase
				end else if (scl_timeout) begin
					err_d = ERR_STRETCH;
					go    = 1'b1;
					nxt   = SP_SCL;
				end else begin
					stimer_d = stimer_inc;
				end
			end
			SP_WAIT: begin
				if (scl_up || scl_timeout) begin
					go  = 1'b1;
					nxt = SP_HIGH;
				end else begin
					stimer_d = stimer_inc;
				end
			end
			ST_SDA, ST_SCL, TX_SETUP, TX_HIGH, AK_SETUP, AK_HIGH, AK_LOW,
			RS_REL, RS_HIGH, RS_SDA, RS_SCL, RX_REL, RX_HIGH, RX_LOW,
			MA_SETUP, MA_HIGH, MA_LOW, SP_SCL, SP_SDA, SP_HIGH, SP_REL: begin
				if (!hold_done) begin
					ptimer_d = ptimer_inc;
				end else begin
					go = 1'b1;
					case (phase_q)
						ST_SDA: nxt = ST_SCL;
						ST_SCL: begin
							shift_d = addr_q;
							bit_d   = '0;
							nxt     = TX_SETUP;
						end
						TX_SETUP: nxt = (bit_q == '0) ? TX_WAIT : TX_HIGH;
						TX_HIGH: begin
							shift_d = {shift_q[6:0], 1'b0};
							if (bit_q == 3'd7) begin
								bit_d = '0;
								nxt   = AK_SETUP;
							end else begin
								bit_d = bit_q + 3'd1;
								nxt   = TX_SETUP;
							end
						end
						AK_SETUP: nxt = AK_WAIT;
						AK_HIGH:  nxt = AK_LOW;
						AK_LOW: begin
							if (nack_q) begin
								err_d = ERR_NACK;
								nxt   = SP_SCL;
							end else if (in_rd_q) begin
								if (bytes_left_q != '0) begin
									bit_d   = '0;
									shift_d = '0;
									nxt     = RX_REL;
								end else begin
									nxt = SP_SCL;
								end
							end else if (sp_q < hwc_q) begin
								shift_d = buf_rdata;
								bit_d   = '0;
								sp_d    = sp_q + PW'(1);
								nxt     = TX_SETUP;
							end else if (is_read_q) begin
								nxt = RS_REL;
							end else begin
								nxt = SP_SCL;
							end
						end
						RS_REL:  nxt = RS_WAIT;
						RS_HIGH: nxt = RS_SDA;
						RS_SDA:  nxt = RS_SCL;
						RS_SCL: begin
							in_rd_d = 1'b1;
							shift_d = addr_q | 8'h01;
							bit_d   = '0;
							nxt     = TX_SETUP;
						end
						RX_REL: begin
							bit_d = '0;
							nxt   = RX_WAIT;
						end
						RX_HIGH: begin
							shift_d = {shift_q[6:0], item.sda_in};
							if (bit_q == 3'd7) begin
								res_d.read_valid = 1'b1;
								res_d.read_byte  = {shift_q[6:0], item.sda_in};
								res_d.read_last  = bytes_left_q == 16'd1;
								bit_d            = '0;
								nxt              = MA_SETUP;
							end else begin
								bit_d = bit_q + 3'd1;
								nxt   = RX_LOW;
							end
						end
						RX_LOW:   nxt = RX_HIGH;
						MA_SETUP: nxt = MA_HIGH;
						MA_HIGH:  nxt = MA_LOW;
						MA_LOW: begin
							bytes_left_d = bl_dec;
							if (bl_dec != '0) begin
								bit_d   = '0;
								shift_d = '0;
								nxt     = RX_REL;
							end else begin
								nxt = SP_SCL;
							end
						end
						SP_SCL: nxt = SP_SDA;
						SP_SDA: nxt = SP_WAIT;
						SP_HIGH: nxt = SP_REL;
						default: begin
							res_d.done_res = 1'b1;
							nxt            = PH_IDLE;
						end
					endcase
				end
			end
			default: begin
				go  = 1'b1;
				nxt = PH_IDLE;
			end
		endcase

		if (go) begin
			phase_d  = nxt;
			ptimer_d = '0;
			stimer_d = '0;
		end

		case (phase_d)
			ST_SDA, RS_SDA, SP_WAIT, SP_HIGH: begin
				res_d.scl_drive_low = 1'b0;
				res_d.sda_drive_low = 1'b1;
			end
			ST_SCL, RS_SCL, SP_SDA: begin
				res_d.scl_drive_low = 1'b1;
				res_d.sda_drive_low = 1'b1;
			end
			TX_SETUP: begin
				res_d.scl_drive_low = 1'b1;
				res_d.sda_drive_low = !shift_d[7];
			end
			TX_WAIT, TX_HIGH: begin
				res_d.scl_drive_low = 1'b0;
				res_d.sda_drive_low = !shift_d[7];
			end
			AK_SETUP, AK_LOW, RS_REL, RX_REL, RX_LOW, SP_SCL: begin
				res_d.scl_drive_low = 1'b1;
				res_d.sda_drive_low = 1'b0;
			end
			MA_SETUP, MA_LOW: begin
				res_d.scl_drive_low = 1'b1;
				res_d.sda_drive_low = bytes_left_d > 16'd1;
			end
			MA_HIGH: begin
				res_d.scl_drive_low = 1'b0;
				res_d.sda_drive_low = bytes_left_d > 16'd1;
			end
			default: begin
				res_d.scl_drive_low = 1'b0;
				res_d.sda_drive_low = 1'b0;
			end
		endcase

		res_d.busy_res   = phase_d != PH_IDLE;
		res_d.error_kind = err_d;
	end

	assign res = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_q        <= '0;
			shift_q      <= '0;
			bytes_left_q <= '0;
			lp_q         <= '0;
			sp_q         <= '0;
			hwc_q        <= '0;
			ptimer_q     <= '0;
			stimer_q     <= '0;
			is_read_q    <= 1'b0;
			addr_q       <= '0;
			err_q        <= ERR_NONE;
			in_rd_q      <= 1'b0;
			nack_q       <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			bit_q        <= bit_d;
			shift_q      <= shift_d;
			bytes_left_q <= bytes_left_d;
			lp_q         <= lp_d;
			sp_q         <= sp_d;
			hwc_q        <= hwc_d;
			ptimer_q     <= ptimer_d;
			stimer_q     <= stimer_d;
			is_read_q    <= is_read_d;
			addr_q       <= addr_d;
			err_q        <= err_d;
			in_rd_q      <= in_rd_d;
			nack_q       <= nack_d;
		end
	end

	`ASSERT_ALWAYS(a_send_ptr_bound, sp_q <= hwc_q, "send pointer ran past write count")
	`ASSERT_NXT(a_start_clears,
		accept && phase_q == PH_IDLE && (item.op == OP_WRITE || item.op == OP_READ),
		phase_q == ST_WAIT && lp_q == '0 && err_q == ERR_NONE,
		"transaction start did not reset sequencer")
	`ASSERT_NXT(a_done_idle, accept && res_d.done_res, phase_q == PH_IDLE,
		"done without returning to idle")
	`ASSERT_IMP(a_rx_last, accept && res_d.read_valid && res_d.read_last,
		bytes_left_q == 16'd1, "last read byte flagged with bytes remaining")

endmodule

### hdl/i2c_master_write_read_engine.sv
// I2C master write/read engine: one tick per input transaction, registered result stream.
// Usage: load write bytes with op LOAD, then issue WRITE or READ; keep ticking (op TICK)
// with the sampled scl_in/sda_in until done_res; drive the pins from each result.
// Input channel s_*: s_tuser carries op, s_tdata the remaining fields.
// Output channel m_*: one result per accepted input; m_tlast marks the last read byte.
// APB port: half_period_ticks at 0x0, stretch_timeout_ticks at 0x4; write only while idle.
// Output: a result is registered in the output register, or in the skid stage on a stall.
// Throughput: one transaction per cycle while s_tready is high; the sequencer updates all
// its state per accepted input; the write buffer RAM is read ahead at the send pointer.
// Stall: the output register plus a one-entry skid stage absorb a stalled receiver;
// s_tready drops once the skid stage holds a result and rises when it drains.
// Reset: clears sequencer state to idle, pointers to zero, errors to none, and the
// registers to 5 and 12000; write buffer contents are undefined until loaded.
// Depends on i2cmwr_pkg, i2cmwr_seq, i2cmwr_skid and i2cmwr_ram.
module i2c_master_write_read_engine #(
	parameter int WRITE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// write_byte[7:0], slave_address[15:8], write_count[20:16], read_count[36:21],
	// scl_in[37], sda_in[38], zero[39]
	input  logic [39:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_drive_low[0], sda_drive_low[1], read_valid[2], read_byte[10:3],
	// busy_res[11], done_res[12], error_kind[14:13], zero[15]
	output logic [15:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import i2cmwr_pkg::*;

	logic [9:0]  half_period_q;
	logic [15:0] timeout_q;
	logic        cfg_we;
	logic        accept;
	item_t       item;
	res_t        res;
	res_t        res_out;
	logic [$bits(res_t)-1:0] res_out_bits;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_q} : {22'd0, half_period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
			timeout_q     <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			if (paddr[2] == REG_HALF_PERIOD) begin
				half_period_q <= pwdata[9:0];
			end else begin
				timeout_q <= pwdata[15:0];
			end
		end
	end

	assign item.op            = s_tuser;
	assign item.write_byte    = s_tdata[7:0];
	assign item.slave_address = s_tdata[15:8];
	assign item.write_count   = s_tdata[20:16];
	assign item.read_count    = s_tdata[36:21];
	assign item.scl_in        = s_tdata[37];
	assign item.sda_in        = s_tdata[38];

	assign accept = s_tvalid && s_tready;

	i2cmwr_seq #(.WRITE_DEPTH(WRITE_DEPTH)) u_seq (
		.clk                   (clk),
		.arst_n                (arst_n),
		.accept                (accept),
		.item                  (item),
		.half_period_ticks     (half_period_q),
		.stretch_timeout_ticks (timeout_q),
		.res                   (res)
	);

	i2cmwr_skid #(.DW($bits(res_t))) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_out_bits)
	);

	assign res_out = res_t'(res_out_bits);

	assign m_tdata = {1'b0, res_out.error_kind, res_out.done_res, res_out.busy_res,
		res_out.read_byte, res_out.read_valid, res_out.sda_drive_low,
		res_out.scl_drive_low};
	assign m_tlast = res_out.read_last;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Stream-level testbench for i2c_master_write_read_engine: emulates an I2C slave on the
// sampled pins, predicts every result word in a cycle-exact model and checks it.
// Depends on i2cmwr_pkg and the engine RTL.
module tb;
	import i2cmwr_pkg::*;

	localparam int BUF_DEPTH = 16;
	localparam int QUIET_LIMIT = 4000;

	typedef enum logic [4:0] {
		PH_IDLE, ST_WAIT, ST_SDA, ST_SCL,
		TX_SETUP, TX_WAIT, TX_HIGH,
		AK_SETUP, AK_WAIT, AK_HIGH, AK_LOW,
		RS_REL, RS_WAIT, RS_HIGH, RS_SDA, RS_SCL,
		RX_REL, RX_WAIT, RX_HIGH, RX_LOW,
		MA_SETUP, MA_HIGH, MA_LOW,
		SP_SCL, SP_SDA, SP_WAIT, SP_HIGH, SP_REL
	} bus_phase_t;

	typedef enum logic [1:0] {SCL_PENDING, SCL_RELEASED, SCL_TIMEOUT} scl_wait_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	i2c_master_write_read_engine u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// sequencer model state
	logic [9:0]  cfg_half = HALF_PERIOD_RESET;
	logic [15:0] cfg_timeout = TIMEOUT_RESET;
	bus_phase_t  ph = PH_IDLE;
	logic [3:0]  bit_idx = '0;
	logic [7:0]  shreg = '0;
	logic [15:0] bytes_left = '0;
	logic [7:0]  wbuf [BUF_DEPTH];
	logic [4:0]  load_ptr = '0;
	logic [4:0]  send_ptr = '0;
	logic [9:0]  ph_timer = '0;
	logic [15:0] st_timer = '0;
	logic        is_read = 1'b0;
	logic [7:0]  held_addr = '0;
	logic [1:0]  held_err = ERR_NONE;
	logic [4:0]  held_wc = '0;
	logic        in_read_stage = 1'b0;
	logic        nack_seen = 1'b0;

	// slave emulation
	res_t        last_res = '0;
	bus_phase_t  pin_phase = PH_IDLE;
	logic [15:0] wait_len = '0;
	logic        ack_high = 1'b0;
	int          stretch_pct = 20;
	int          stretch_max = 4;
	int          nack_pct = 0;

	res_t predicted_results[$];
	int   src_idle_pct = 14;
	int   sink_idle_pct = 74;
	int   hold_left = 0;
	int   items_sent = 0;
	int   errors = 0;
	int   quiet_cycles = 0;

	function automatic void go(bus_phase_t p);
		ph = p;
		ph_timer = '0;
		st_timer = '0;
	endfunction

	function automatic logic held_long();
		logic [9:0] hp;
		hp = (cfg_half == 10'd0) ? 10'd1 : cfg_half;
		ph_timer = ph_timer + 10'd1;
		return ph_timer >= hp;
	endfunction

	function automatic scl_wait_t scl_check(logic scl);
		logic [15:0] to;
		to = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
		if (scl)
			return SCL_RELEASED;
		st_timer = st_timer + 16'd1;
		return (st_timer >= to) ? SCL_TIMEOUT : SCL_PENDING;
	endfunction

	function automatic void abort_to_stop(logic [1:0] kind);
		held_err = kind;
		go(SP_SCL);
	endfunction

	function automatic void shift_out(logic [7:0] b);
		shreg = b;
		bit_idx = '0;
		go(TX_SETUP);
	endfunction

	function automatic void after_ack();
		logic [7:0] b;
		if (in_read_stage) begin
			if (bytes_left != 16'd0) begin
				bit_idx = '0;
				shreg = '0;
				go(RX_REL);
			end else
				go(SP_SCL);
		end else if (send_ptr < held_wc) begin
			b = wbuf[send_ptr[3:0]];
			send_ptr = send_ptr + 5'd1;
			shift_out(b);
		end else if (is_read)
			go(RS_REL);
		else
			go(SP_SCL);
	endfunction

	function automatic res_t sequencer_step(item_t it);
		res_t r;
		scl_wait_t w;
		logic b;
		r = '0;
		case (ph)
			PH_IDLE: begin
				if (it.op == OP_LOAD) begin
					if (load_ptr < 5'(BUF_DEPTH)) begin
						wbuf[load_ptr[3:0]] = it.write_byte;
						load_ptr = load_ptr + 5'd1;
					end
				end else if (it.op == OP_WRITE || it.op == OP_READ) begin
					held_addr = it.slave_address;
					held_wc = (it.write_count > 5'(BUF_DEPTH)) ? 5'(BUF_DEPTH) : it.write_count;
					is_read = (it.op == OP_READ);
					bytes_left = is_read ? it.read_count : 16'd0;
					send_ptr = '0;
					load_ptr = '0;
					held_err = ERR_NONE;
					in_read_stage = 1'b0;
					nack_seen = 1'b0;
					bit_idx = '0;
					shreg = '0;
					go(ST_WAIT);
				end
			end
			ST_WAIT: begin
				w = scl_check(it.scl_in);
				if (w == SCL_RELEASED) go(ST_SDA);
				else if (w == SCL_TIMEOUT) abort_to_stop(ERR_STRETCH);
			end
			ST_SDA: if (held_long()) go(ST_SCL);
			ST_SCL: if (held_long()) shift_out(held_addr);
			TX_SETUP: if (held_long()) go((bit_idx == 4'd0) ? TX_WAIT : TX_HIGH);
			TX_WAIT: begin
				w = scl_check(it.scl_in);
				if (w == SCL_RELEASED) go(TX_HIGH);
				else if (w == SCL_TIMEOUT) abort_to_stop(ERR_STRETCH);
			end
			TX_HIGH: begin
				if (held_long()) begin
					shreg = shreg << 1;
					if (bit_idx >= 4'd7) begin
						bit_idx = '0;
						go(AK_SETUP);
					end else begin
						bit_idx = bit_idx + 4'd1;
						go(TX_SETUP);
					end
				end
			end
			AK_SETUP: if (held_long()) go(AK_WAIT);
			AK_WAIT: begin
				w = scl_check(it.scl_in);
				if (w == SCL_RELEASED) begin
					nack_seen = it.sda_in;
					go(AK_HIGH);
				end else if (w == SCL_TIMEOUT) abort_to_stop(ERR_STRETCH);
			end
			AK_HIGH: if (held_long()) go(AK_LOW);
			AK_LOW: begin
				if (held_long()) begin
					if (nack_seen) abort_to_stop(ERR_NACK);
					else after_ack();
				end
			end
			RS_REL: if (held_long()) go(RS_WAIT);
			RS_WAIT: begin
				w = scl_check(it.scl_in);
				if (w == SCL_RELEASED) go(RS_HIGH);
				else if (w == SCL_TIMEOUT) abort_to_stop(ERR_STRETCH);
			end
			RS_HIGH: if (held_long()) go(RS_SDA);
			RS_SDA: if (held_long()) go(RS_SCL);
			RS_SCL: begin
				if (held_long()) begin
					in_read_stage = 1'b1;
					shift_out(held_addr | 8'h01);
				end
			end
			RX_REL: begin
				if (held_long()) begin
					bit_idx = '0;
					go(RX_WAIT);
				end
			end
			RX_WAIT: begin
				w = scl_check(it.scl_in);
				if (w == SCL_RELEASED) go(RX_HIGH);
				else if (w == SCL_TIMEOUT) abort_to_stop(ERR_STRETCH);
			end
			RX_HIGH: begin
				if (held_long()) begin
					shreg = {shreg[6:0], it.sda_in};
					if (bit_idx >= 4'd7) begin
						r.read_valid = 1'b1;
						r.read_byte = shreg;
						r.read_last = (bytes_left == 16'd1);
						bit_idx = '0;
						go(MA_SETUP);
					end else begin
						bit_idx = bit_idx + 4'd1;
						go(RX_LOW);
					end
				end
			end
			RX_LOW: if (held_long()) go(RX_HIGH);
			MA_SETUP: if (held_long()) go(MA_HIGH);
			MA_HIGH: if (held_long()) go(MA_LOW);
			MA_LOW: begin
				if (held_long()) begin
					if (bytes_left != 16'd0) bytes_left = bytes_left - 16'd1;
					if (bytes_left != 16'd0) begin
						bit_idx = '0;
						shreg = '0;
						go(RX_REL);
					end else
						go(SP_SCL);
				end
			end
			SP_SCL: if (held_long()) go(SP_SDA);
			SP_SDA: if (held_long()) go(SP_WAIT);
			SP_WAIT: if (scl_check(it.scl_in) != SCL_PENDING) go(SP_HIGH);
			SP_HIGH: if (held_long()) go(SP_REL);
			SP_REL: begin
				if (held_long()) begin
					r.done_res = 1'b1;
					go(PH_IDLE);
				end
			end
			default: go(PH_IDLE);
		endcase

		b = ~shreg[7];
		case (ph)
			ST_SDA, RS_SDA, SP_WAIT, SP_HIGH: {r.scl_drive_low, r.sda_drive_low} = 2'b01;
			ST_SCL, RS_SCL, SP_SDA: {r.scl_drive_low, r.sda_drive_low} = 2'b11;
			TX_SETUP: {r.scl_drive_low, r.sda_drive_low} = {1'b1, b};
			TX_WAIT, TX_HIGH: {r.scl_drive_low, r.sda_drive_low} = {1'b0, b};
			AK_SETUP, AK_LOW, RS_REL, RX_REL, RX_LOW, SP_SCL:
				{r.scl_drive_low, r.sda_drive_low} = 2'b10;
			MA_SETUP, MA_LOW:
				{r.scl_drive_low, r.sda_drive_low} = {1'b1, bytes_left > 16'd1};
			MA_HIGH: {r.scl_drive_low, r.sda_drive_low} = {1'b0, bytes_left > 16'd1};
			default: {r.scl_drive_low, r.sda_drive_low} = 2'b00;
		endcase
		r.busy_res = (ph != PH_IDLE);
		r.error_kind = held_err;
		return r;
	endfunction

	// answer as a slave would: stretch on released SCL, ACK or NACK, random read data
	function automatic item_t bus_response(item_t it);
		if (ph != pin_phase) begin
			pin_phase = ph;
			wait_len = ($urandom_range(0, 99) < stretch_pct) ?
				16'($urandom_range(1, stretch_max)) : 16'd0;
			ack_high = ($urandom_range(0, 99) < nack_pct) || (bytes_left > 16'd6);
		end
		it.scl_in = ~last_res.scl_drive_low;
		if ($urandom_range(0, 9) == 0) it.scl_in = 1'($urandom_range(0, 1));
		case (ph)
			ST_WAIT, TX_WAIT, AK_WAIT, RS_WAIT, RX_WAIT, SP_WAIT:
				it.scl_in = (st_timer >= wait_len);
			default: ;
		endcase
		if (ph == AK_WAIT) it.sda_in = ack_high;
		return it;
	endfunction

	function automatic item_t random_item();
		logic [63:0] bits;
		item_t it;
		bits = {$urandom, $urandom};
		it = bits[40:0];
		return it;
	endfunction

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	task automatic send_item(input item_t raw);
		item_t it;
		res_t r;
		it = bus_response(raw);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {1'b0, it.sda_in, it.scl_in, it.read_count, it.write_count,
			it.slave_address, it.write_byte};
		do @(posedge clk); while (!s_tready);
		r = sequencer_step(it);
		last_res = r;
		predicted_results.push_back(r);
		items_sent++;
	endtask

	task automatic send_load(input logic [7:0] b);
		item_t it;
		it = random_item();
		it.op = OP_LOAD;
		it.write_byte = b;
		send_item(it);
	endtask

	task automatic run_transfer(input logic [1:0] op, input logic [7:0] addr,
			input logic [4:0] wc, input logic [15:0] rc);
		item_t it;
		it = random_item();
		it.op = op;
		it.slave_address = addr;
		it.write_count = wc;
		it.read_count = rc;
		send_item(it);
		while (ph != PH_IDLE) begin
			it = random_item();
			if ($urandom_range(0, 99) >= 15) it.op = OP_TICK;
			send_item(it);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (predicted_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic sel, input logic [31:0] val);
		logic [31:0] want;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == REG_HALF_PERIOD) cfg_half = val[9:0];
		else cfg_timeout = val[15:0];
		want = (sel == REG_HALF_PERIOD) ? {22'd0, cfg_half} : {16'd0, cfg_timeout};
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		compare_field("prdata", want[15:0], prdata[15:0]);
		compare_field("prdata_hi", 16'd0, prdata[31:16]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic [9:0] hp, input logic [15:0] to);
		drain();
		apb_write(REG_HALF_PERIOD, {22'd0, hp});
		apb_write(REG_TIMEOUT, {16'd0, to});
	endtask

	task automatic test_load_buffer();
		send_load(8'h00);
		send_load(8'hFF);
		repeat (15) send_load(8'($urandom_range(0, 255)));
		run_transfer(OP_WRITE, 8'hA4, 5'd0, 16'd0);
	endtask

	task automatic test_write();
		set_config(10'd1, TIMEOUT_RESET);
		run_transfer(OP_WRITE, 8'hFF, 5'd0, 16'd0);
		send_load(8'h81);
		run_transfer(OP_WRITE, 8'h00, 5'd31, 16'd0);
	endtask

	task automatic test_read();
		run_transfer(OP_READ, 8'h90, 5'd0, 16'd0);
		run_transfer(OP_READ, 8'h91, 5'd0, 16'd1);
		run_transfer(OP_READ, 8'h3E, 5'd1, 16'd2);
	endtask

	task automatic test_nack();
		nack_pct = 100;
		run_transfer(OP_WRITE, 8'h20, 5'd2, 16'd0);
		run_transfer(OP_READ, 8'h21, 5'd0, 16'hFFFF);
		nack_pct = 30;
		run_transfer(OP_READ, 8'h44, 5'd1, 16'd2);
		nack_pct = 0;
	endtask

	task automatic test_stretch_timeout();
		set_config(10'd2, 16'd2);
		stretch_pct = 100;
		stretch_max = 5;
		run_transfer(OP_WRITE, 8'h6A, 5'd2, 16'd0);
		run_transfer(OP_READ, 8'h6A, 5'd1, 16'd3);
		stretch_pct = 20;
		stretch_max = 4;
		set_config(10'd1, TIMEOUT_RESET);
	endtask

	task automatic test_period_extremes();
		set_config(10'd1023, 16'hFFFF);
		set_config(10'd0, 16'd0);
		stretch_pct = 40;
		stretch_max = 3;
		run_transfer(OP_READ, 8'hC3, 5'd1, 16'd2);
		stretch_pct = 20;
		stretch_max = 4;
	endtask

	task automatic test_backpressure();
		set_config(10'd1, TIMEOUT_RESET);
		hold_left = 400;
		run_transfer(OP_WRITE, 8'h5A, 5'd3, 16'd0);
	endtask

	task automatic test_random_traffic(input int n_items);
		int first;
		item_t it;
		logic [9:0] hp;
		logic [15:0] to;
		logic [15:0] rc;
		logic [4:0] wc;
		first = items_sent;
		while (items_sent - first < n_items) begin
			if ($urandom_range(0, 3) == 0) begin
				hp = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(1, 2)) :
					10'($urandom_range(0, 4));
				if ($urandom_range(0, 1) == 1) begin
					to = 16'($urandom_range(1, 6));
					stretch_max = 8;
				end else begin
					to = 16'($urandom_range(200, 65535));
					stretch_max = 12;
				end
				set_config(hp, to);
			end
			repeat ($urandom_range(0, 4)) send_load(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 2)) begin
				it = random_item();
				it.op = OP_TICK;
				send_item(it);
			end
			nack_pct = ($urandom_range(0, 4) == 0) ? 40 : 0;
			wc = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
			rc = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
			run_transfer(($urandom_range(0, 1) == 1) ? OP_READ : OP_WRITE,
				8'($urandom_range(0, 255)), wc, rc);
		end
		nack_pct = 0;
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_results.size() == 0) begin
				$error("result with nothing expected: tdata %0h", m_tdata);
				errors++;
			end else begin
				want = predicted_results.pop_front();
				compare_field("scl_drive_low", 16'(want.scl_drive_low), 16'(m_tdata[0]));
				compare_field("sda_drive_low", 16'(want.sda_drive_low), 16'(m_tdata[1]));
				compare_field("read_valid", 16'(want.read_valid), 16'(m_tdata[2]));
				compare_field("read_byte", 16'(want.read_byte), 16'(m_tdata[10:3]));
				compare_field("read_last", 16'(want.read_last), 16'(m_tlast));
				compare_field("busy_res", 16'(want.busy_res), 16'(m_tdata[11]));
				compare_field("done_res", 16'(want.done_res), 16'(m_tdata[12]));
				compare_field("error_kind", 16'(want.error_kind), 16'(m_tdata[14:13]));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = OP_TICK;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_load_buffer();
		test_write();
		test_read();
		test_nack();
		test_stretch_timeout();
		test_random_traffic(60);

		src_idle_pct = 74;
		sink_idle_pct = 14;
		test_random_traffic(60);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_traffic(60);
		test_period_extremes();
		test_backpressure();

		drain();
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
